@@ sv/ppu_register_and_vram_port_unit_macros.svh @@
// assertion macros used by the rtl
`ifndef PPU_REGISTER_AND_VRAM_PORT_UNIT_MACROS_SVH
`define PPU_REGISTER_AND_VRAM_PORT_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define PPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define PPU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PPU_ASSERT(lbl, prop, msg)
`define PPU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ sv/ppu_pkg.sv @@
package ppu_pkg;

  localparam int PATTERN_BYTES   = 8192;
  localparam int NAMETABLE_BYTES = 2048;
  localparam int SPRITE_BYTES    = 256;
  localparam int PALETTE_ENTRIES = 32;

  localparam int PAT_AW = $clog2(PATTERN_BYTES);
  localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
  localparam int OAM_AW = $clog2(SPRITE_BYTES);
  localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLAGS = 2'd2;

  // register numbers
  localparam logic [2:0] REG_CTRL    = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_OAMADDR = 3'd3;
  localparam logic [2:0] REG_OAMDATA = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_ADDR    = 3'd6;
  localparam logic [2:0] REG_DATA    = 3'd7;

  // configuration word index (paddr bit 2)
  localparam logic CFG_MIRROR = 1'b0;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WR_CTRL,
    OP_WR_MASK,
    OP_WR_OAMADDR,
    OP_WR_OAMDATA,
    OP_WR_SCROLL,
    OP_WR_ADDR,
    OP_WR_DATA,
    OP_RD_STATUS,
    OP_RD_OAMDATA,
    OP_RD_DATA,
    OP_LOAD_FLAGS
  } op_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] reg_sel;
    logic [7:0] wdata;
  } ppu_in_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic [14:0] vram_address;
  } ppu_out_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } ppu_entry_t;

  typedef struct packed {
    logic       valid;
    ppu_entry_t entry;
  } ppu_queue_t;

endpackage

@@ sv/ppu_register_and_vram_port_unit.sv @@
// an accepted word waits in the queue until the idle state takes it; the execute state
// then registers its result and strobe, and the queue keeps taking words meanwhile
// two words may wait in the queue; busy rises when it is full and during the clearing pass
// reset: all registers clear at once, then a clearing pass over every pattern memory address
// zeroes the memories while busy stays high; apb writes are taken throughout
// results come for one cycle on done_o and the receiver cannot stall them
module ppu_register_and_vram_port_unit
  import ppu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // command side
  input  logic        start,
  output logic        busy,
  input  ppu_in_t     item_i,
  output logic        done_o,
  output ppu_out_t    result_o,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // mirroring select, written only while the block is quiet: a rule for the user, unchecked by the block
  logic       mirror_q;
  logic       cfg_we;
  logic       q_full;
  logic       clearing;
  logic       pop;
  ppu_queue_t queue;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == CFG_MIRROR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q <= 1'b0;
    end else if (cfg_we) begin
      mirror_q <= pwdata[0];
    end
  end

  // word 0 holds the mirroring bit, the rest reads as zero
  assign prdata = (paddr[2] == CFG_MIRROR) ? {31'd0, mirror_q} : 32'd0;

  // accept while the queue has room and the memories are ready
  assign busy = q_full || clearing;

  // front: decode the access and queue it
  ppu_front u_front (
    .clk_i,
    .rst_ni,
    .push_i  (start && !busy),
    .item_i,
    .pop_i   (pop),
    .queue_o (queue),
    .full_o  (q_full)
  );

  // back: registers, object memory and video memory, an idle and an execute state per word
  ppu_back u_back (
    .clk_i,
    .rst_ni,
    .mirror_vertical_i (mirror_q),
    .queue_i           (queue),
    .pop_o             (pop),
    .clearing_o        (clearing),
    .done_o,
    .result_o
  );

endmodule

@@ sv/ppu_ram.sv @@
module ppu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ppu_front.sv @@
module ppu_front
  import ppu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ppu_in_t    item_i,
  input  logic       pop_i,
  output ppu_queue_t queue_o,
  output logic       full_o
);

  ppu_entry_t        entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  ppu_entry_t        entry_d;
  logic              do_push, do_pop;

  // decode the access into one operation
  always_comb begin
    entry_d.data = item_i.wdata;
    entry_d.op   = OP_NONE;
    case (item_i.cmd)
      CMD_FLAGS: entry_d.op = OP_LOAD_FLAGS;
      CMD_WRITE: begin
        case (item_i.reg_sel)
          REG_CTRL:    entry_d.op = OP_WR_CTRL;
          REG_MASK:    entry_d.op = OP_WR_MASK;
          REG_OAMADDR: entry_d.op = OP_WR_OAMADDR;
          REG_OAMDATA: entry_d.op = OP_WR_OAMDATA;
          REG_SCROLL:  entry_d.op = OP_WR_SCROLL;
          REG_ADDR:    entry_d.op = OP_WR_ADDR;
          REG_DATA:    entry_d.op = OP_WR_DATA;
          default:     entry_d.op = OP_NONE;
        endcase
      end
      CMD_READ: begin
        case (item_i.reg_sel)
          REG_STATUS:  entry_d.op = OP_RD_STATUS;
          REG_OAMDATA: entry_d.op = OP_RD_OAMDATA;
          REG_DATA:    entry_d.op = OP_RD_DATA;
          default:     entry_d.op = OP_NONE;
        endcase
      end
      default: entry_d.op = OP_NONE;
    endcase
  end

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && (cnt_q != '0);

  assign queue_o.valid = (cnt_q != '0);
  assign queue_o.entry = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= entry_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ sv/ppu_back.sv @@
`include "ppu_register_and_vram_port_unit_macros.svh"

module ppu_back
  import ppu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       mirror_vertical_i,
  input  ppu_queue_t queue_i,
  output logic       pop_o,
  output logic       clearing_o,
  output logic       done_o,
  output ppu_out_t   result_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e            state_q;
  logic [PAT_AW-1:0] clr_q;
  ppu_entry_t        op_q;
  logic              done_q;
  ppu_out_t          res_q;

  logic [7:0]  ctrl_q, mask_q, oam_addr_q, rbuf_q;
  logic [2:0]  flags_q, fine_x_q;
  logic [14:0] v_q, t_q;
  logic        w_q;

  logic              clearing, exec;
  logic              is_pat, is_pal;
  logic [PAT_AW-1:0] pat_addr;
  logic [NT_AW-1:0]  nt_addr;
  logic [PAL_AW-1:0] pal_idx, pal_addr;
  logic [OAM_AW-1:0] oam_ram_addr;
  logic              pat_we, nt_we, pal_we, oam_we;
  logic [7:0]        wr_byte;
  logic [7:0]        pat_rd, nt_rd, pal_rd, oam_rd;
  logic [7:0]        mem_byte;
  logic [14:0]       v_inc, v_d;
  logic [7:0]        r_d;

  assign clearing = (state_q == S_CLEAR);
  assign exec     = (state_q == S_EXEC);

  // region decode of the 14-bit video address
  assign is_pat = !v_q[13];
  assign is_pal = (v_q[13:8] == 6'h3F);

  always_comb begin
    pal_idx = v_q[PAL_AW-1:0];
    // backdrop mirrors of the sprite palettes
    if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
      pal_idx[4] = 1'b0;
    end
  end

  assign pat_addr     = clearing ? clr_q : v_q[PAT_AW-1:0];
  assign nt_addr      = clearing ? clr_q[NT_AW-1:0]
                      : {(mirror_vertical_i ? v_q[10] : v_q[11]), v_q[9:0]};
  assign pal_addr     = clearing ? clr_q[PAL_AW-1:0] : pal_idx;
  assign oam_ram_addr = clearing ? clr_q[OAM_AW-1:0] : oam_addr_q;

  assign wr_byte = clearing ? 8'h00 : op_q.data;
  assign pat_we  = clearing || (exec && (op_q.op == OP_WR_DATA) && is_pat);
  assign pal_we  = clearing || (exec && (op_q.op == OP_WR_DATA) && is_pal);
  assign nt_we   = clearing || (exec && (op_q.op == OP_WR_DATA) && !is_pat && !is_pal);
  assign oam_we  = clearing || (exec && (op_q.op == OP_WR_OAMDATA));

  ppu_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat_ram (
    .clk_i, .we_i(pat_we), .addr_i(pat_addr), .wdata_i(wr_byte), .rdata_o(pat_rd)
  );
  ppu_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nt_ram (
    .clk_i, .we_i(nt_we), .addr_i(nt_addr), .wdata_i(wr_byte), .rdata_o(nt_rd)
  );
  ppu_ram #(.WIDTH(8), .DEPTH(PALETTE_ENTRIES)) u_pal_ram (
    .clk_i, .we_i(pal_we), .addr_i(pal_addr), .wdata_i(wr_byte), .rdata_o(pal_rd)
  );
  ppu_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_oam_ram (
    .clk_i, .we_i(oam_we), .addr_i(oam_ram_addr), .wdata_i(wr_byte), .rdata_o(oam_rd)
  );

  // read data is valid in exec: address held since the pop cycle
  always_comb begin
    if (is_pat) begin
      mem_byte = pat_rd;
    end else if (is_pal) begin
      mem_byte = pal_rd & (mask_q[0] ? 8'h30 : 8'h3F);
    end else begin
      mem_byte = nt_rd;
    end
  end

  assign v_inc = v_q + (ctrl_q[2] ? 15'd32 : 15'd1);

  always_comb begin
    v_d = v_q;
    r_d = 8'h00;
    case (op_q.op)
      OP_WR_ADDR:    if (w_q) v_d = {t_q[14:8], op_q.data};
      OP_WR_DATA:    v_d = v_inc;
      OP_RD_STATUS:  r_d = {flags_q, rbuf_q[4:0]};
      OP_RD_OAMDATA: r_d = oam_rd;
      OP_RD_DATA: begin
        v_d = v_inc;
        r_d = is_pal ? mem_byte : rbuf_q;
      end
      default: begin
        v_d = v_q;
        r_d = 8'h00;
      end
    endcase
  end

  assign pop_o = (state_q == S_IDLE) && queue_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      op_q       <= '{op: OP_NONE, data: 8'h00};
      done_q     <= 1'b0;
      res_q      <= '0;
      ctrl_q     <= '0;
      mask_q     <= '0;
      flags_q    <= '0;
      oam_addr_q <= '0;
      v_q        <= '0;
      t_q        <= '0;
      fine_x_q   <= '0;
      w_q        <= 1'b0;
      rbuf_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (queue_i.valid) begin
            op_q    <= queue_i.entry;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q            <= S_IDLE;
          done_q             <= 1'b1;
          res_q.rdata        <= r_d;
          res_q.vram_address <= v_d;
          v_q                <= v_d;
          case (op_q.op)
            OP_WR_CTRL: begin
              ctrl_q      <= op_q.data;
              t_q[11:10]  <= op_q.data[1:0];
            end
            OP_WR_MASK:    mask_q <= op_q.data;
            OP_WR_OAMADDR: oam_addr_q <= op_q.data;
            OP_WR_OAMDATA: oam_addr_q <= oam_addr_q + 8'd1;
            OP_WR_SCROLL: begin
              if (!w_q) begin
                fine_x_q <= op_q.data[2:0];
                t_q[4:0] <= op_q.data[7:3];
                w_q      <= 1'b1;
              end else begin
                t_q[14:12] <= op_q.data[2:0];
                t_q[9:5]   <= op_q.data[7:3];
                w_q        <= 1'b0;
              end
            end
            OP_WR_ADDR: begin
              if (!w_q) begin
                t_q[14]   <= 1'b0;
                t_q[13:8] <= op_q.data[5:0];
                w_q       <= 1'b1;
              end else begin
                t_q[7:0] <= op_q.data;
                w_q      <= 1'b0;
              end
            end
            OP_RD_STATUS: begin
              flags_q[2] <= 1'b0;
              w_q        <= 1'b0;
            end
            OP_RD_DATA:    rbuf_q <= mem_byte;
            OP_LOAD_FLAGS: flags_q <= op_q.data[7:5];
            default: begin
              w_q <= w_q;
            end
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign clearing_o = clearing;
  assign done_o     = done_q;
  assign result_o   = res_q;

  // a result word follows exactly one execute cycle
  `PPU_ASSERT(a_done_after_exec, done_q |-> $past(state_q == S_EXEC),
              "result strobe without an execute cycle")
  // outside the clearing pass at most one video memory is written
  `PPU_ASSERT(a_one_vram_write, (state_q != S_CLEAR) |-> $onehot0({pat_we, nt_we, pal_we}),
              "more than one video memory written")
  // v moves only at the end of an execute cycle
  `PPU_ASSERT(a_v_only_in_exec, ($past(state_q) != S_EXEC) |-> $stable(v_q),
              "v changed outside execute")

endmodule
